// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the ring buffer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define ORB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring buffer check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define ORB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring buffer check failed");

`endif

// ===== rtl/core/orb_pkg.sv =====
// shared constants, request codes and command types of the ring buffer
package orb_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int SIZE_W     = 5;
    localparam int RES_W      = 32;
    localparam int IDX_W      = 9;

    // request codes carried on s_tuser
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the request and read its slot
        logic execute;   // update the ring and load the result register
    } orb_cmd_t;

endpackage

// ===== rtl/core/orb_ctrl.sv =====
// controller: request handshake, two-step sequence and output valid flag
module orb_ctrl
    import orb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output orb_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } orb_state_t;

    orb_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    // take a request only when idle and the result slot is free by the next edge
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    assign cmd.capture = accept;
    assign cmd.execute = (state_reg == ST_EXEC);

    // sequence and output flag next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "assert_macros.svh"

    `ORB_ASSERT_NEXT(a_accept_then_exec, accept, state_reg == ST_EXEC)
    `ORB_ASSERT_IMPL(a_exec_slot_free, state_reg == ST_EXEC, !out_valid_reg)
    `ORB_ASSERT_NEXT(a_exec_gives_result, state_reg == ST_EXEC, out_valid_reg)

endmodule

// ===== rtl/core/orb_dp.sv =====
// datapath: slot store, positions, empty flag, request and result registers
module orb_dp
    import orb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  orb_cmd_t                cmd,
    input  logic [1:0]              req_type,
    input  logic [DATA_WIDTH-1:0]   push_value,
    input  logic signed [IDX_W-1:0] peek_index,
    input  logic                    cfg_we,
    input  logic [SIZE_W-1:0]       cfg_wdata,
    output logic [RES_W-1:0]        result_value
);

    logic [DATA_WIDTH-1:0] slot_reg [DEPTH];
    logic [DEPTH-1:0]      valid_reg, valid_next;
    logic [PTR_W-1:0]      wr_pos_reg, wr_pos_next;
    logic [PTR_W-1:0]      rd_pos_reg, rd_pos_next;
    logic                  empty_reg, empty_next;
    logic [SIZE_W-1:0]     size_reg;
    logic [SIZE_W-1:0]     size_sat;

    logic [1:0]            req_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic                  zero_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [RES_W-1:0]      result_reg, result_next;

    logic [PTR_W-1:0]      rd_addr;
    logic [SIZE_W-1:0]     peek_sum;
    logic                  peek_far;
    logic [DATA_WIDTH-1:0] rd_word;
    logic                  mem_we;
    logic [PTR_W-1:0]      wr_next_pos;
    logic [PTR_W-1:0]      rd_next_pos;

    // advance a position, wrapping at the ring size
    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p,
                                                 input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] inc;
        inc = {1'b0, p} + SIZE_W'(1);
        next_pos = (inc >= sz) ? '0 : inc[PTR_W-1:0];
    endfunction

    // saturate the written size into 1..DEPTH
    always_comb
    begin
        size_sat = cfg_wdata;
        if (cfg_wdata == '0)
        begin
            size_sat = SIZE_W'(1);
        end
        else if (cfg_wdata > SIZE_W'(DEPTH))
        begin
            size_sat = SIZE_W'(DEPTH);
        end
    end

    // slot address of the request: write slot, oldest slot, newest slot or offset
    assign peek_sum = {1'b0, rd_pos_reg} + {1'b0, peek_index[PTR_W-1:0]};
    assign peek_far = !peek_index[IDX_W-1] && ({1'b0, peek_index[IDX_W-2:0]} >=
                      {{(IDX_W-SIZE_W){1'b0}}, size_reg});

    always_comb
    begin
        case (req_type)
            REQ_PUSH: rd_addr = wr_pos_reg;
            REQ_POP:  rd_addr = rd_pos_reg;
            REQ_PEEK:
            begin
                if (peek_index[IDX_W-1])
                begin
                    rd_addr = (wr_pos_reg == '0) ? PTR_W'(size_reg - SIZE_W'(1))
                                                 : wr_pos_reg - PTR_W'(1);
                end
                else if (peek_sum >= size_reg)
                begin
                    rd_addr = PTR_W'(peek_sum - size_reg);
                end
                else
                begin
                    rd_addr = peek_sum[PTR_W-1:0];
                end
            end
            default:  rd_addr = rd_pos_reg;
        endcase
    end

    // request registers and registered slot read
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= req_type;
            value_reg    <= push_value;
            zero_reg     <= (req_type == REQ_PEEK) && peek_far;
            rd_data_reg  <= slot_reg[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_word     = rd_valid_reg ? rd_data_reg : '0;
    assign wr_next_pos = next_pos(wr_pos_reg, size_reg);
    assign rd_next_pos = next_pos(rd_pos_reg, size_reg);

    // ring update for the captured request
    always_comb
    begin
        valid_next  = valid_reg;
        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        empty_next  = empty_reg;
        result_next = result_reg;
        mem_we      = 1'b0;
        if (cmd.execute)
        begin
            result_next = '0;
            case (req_reg)
                REQ_PUSH:
                begin
                    mem_we                 = 1'b1;
                    valid_next[wr_pos_reg] = 1'b1;
                    wr_pos_next            = wr_next_pos;
                    empty_next             = 1'b0;
                    if (rd_word != '0)
                    begin
                        result_next = RES_W'(rd_word);
                        rd_pos_next = wr_next_pos;
                    end
                    else if (empty_reg)
                    begin
                        rd_pos_next = wr_pos_reg;
                    end
                end
                REQ_POP:
                begin
                    if (!empty_reg)
                    begin
                        result_next            = RES_W'(rd_word);
                        valid_next[rd_pos_reg] = 1'b0;
                        rd_pos_next            = rd_next_pos;
                        if (rd_next_pos == wr_pos_reg)
                        begin
                            empty_next = 1'b1;
                        end
                    end
                end
                REQ_PEEK:
                begin
                    if (!empty_reg && !zero_reg)
                    begin
                        result_next = RES_W'(rd_word);
                    end
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
    end

    // slot store write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_reg[wr_pos_reg] <= value_reg;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_value = result_reg;

    // ring state, cleared by reset and by a size write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
            empty_reg  <= 1'b1;
            size_reg   <= SIZE_W'(DEPTH);
        end
        else if (cfg_we)
        begin
            valid_reg  <= '0;
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
            empty_reg  <= 1'b1;
            size_reg   <= size_sat;
        end
        else
        begin
            valid_reg  <= valid_next;
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
            empty_reg  <= empty_next;
        end
    end

`include "assert_macros.svh"

    `ORB_ASSERT_IMPL(a_wr_pos_in_ring, 1'b1, {1'b0, wr_pos_reg} < size_reg)
    `ORB_ASSERT_IMPL(a_rd_pos_in_ring, 1'b1, {1'b0, rd_pos_reg} < size_reg)
    `ORB_ASSERT_NEXT(a_cfg_clears, cfg_we, empty_reg && valid_reg == '0)

endmodule

// ===== rtl/core/overwriting_ring_buffer.sv =====
// top level of the overwriting ring buffer: controller plus datapath
//
// Usage:
//   Requests enter on the s_ channel: s_tuser holds the request code (push,
//   pop, peek), s_tdata holds the push word and the signed peek index.
//   Every request gives exactly one result word on the m_ channel: the word
//   displaced by a push, the popped word, or the peeked word, 0 when none.
//   cfg_we with cfg_wdata sets the number of slots in use (saturated to
//   1..16) and clears the ring; write it only while no request is pending.
//   After acceptance a request passes through the execute state, where the
//   ring update happens, and then m_tvalid rises; the slot read is registered
//   at acceptance. A new request is taken only once the controller is idle.
//   A finished result waits in the output register; the next request is
//   taken while that result is being taken in the same cycle.
//   When the receiver stalls, the result holds and s_tready stays low once a
//   new request would need the output register.
//   Reset empties the ring, sets the size to 16 and drops m_tvalid.
module overwriting_ring_buffer
    import orb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // push_value[31:0], peek_index[40:32], zero fill
    input  logic [1:0]            s_tuser,   // req_type[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [RES_W-1:0]      m_tdata,   // result_value[31:0]
    input  logic                  cfg_we,
    input  logic [SIZE_W-1:0]     cfg_wdata
);

    orb_cmd_t cmd;

    // sequencing and handshake
    orb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // storage and ring arithmetic
    orb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (s_tuser),
        .push_value   (s_tdata[DATA_WIDTH-1:0]),
        .peek_index   (s_tdata[DATA_WIDTH+IDX_W-1:DATA_WIDTH]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_value (m_tdata)
    );

endmodule
